// ===== sv/rational_arith_reduce_assert.svh =====
// Assertion macros shared by the fraction reduction RTL.
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RAR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rar_pkg.sv =====
// Types and constants shared by the fraction reduction block.
`timescale 1ns / 1ps
package rar_pkg;

    // Fixed result field widths.
    localparam int NUM_WIDTH = 33;
    localparam int DEN_WIDTH = 32;
    // Width of the wrapping cross-product arithmetic at its widest.
    localparam int WIDE = 64;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_TWOS,
        S_ODD,
        S_DIVN,
        S_DIVD,
        S_FINISH
    } state_t;

    // Status of the shared subtractor.
    typedef struct packed {
        logic neg;
        logic zero;
    } sub_flags_t;

endpackage

// ===== sv/rar_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module rar_mul #(
    parameter int WIDTH = 16
) (
    input  logic                      clk,
    input  logic signed [WIDTH-1:0]   a,
    input  logic signed [WIDTH-1:0]   b,
    output logic signed [2*WIDTH-1:0] prod
);
    logic signed [2*WIDTH-1:0] prod_reg;

    // The full-width product is exact for two signed operands.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/rar_sub.sv =====
// Shared subtract and compare unit for the gcd loop and the divisions.
`timescale 1ns / 1ps
module rar_sub #(
    parameter int WIDTH = 35
) (
    input  logic [WIDTH-1:0]    a,
    input  logic [WIDTH-1:0]    b,
    output logic [WIDTH-1:0]    diff,
    output rar_pkg::sub_flags_t flags
);
    import rar_pkg::*;

    // Operands arrive zero-extended, so the top bit of the difference is the borrow.
    always_comb
    begin
        diff       = a - b;
        flags.neg  = diff[WIDTH-1];
        flags.zero = (diff == '0);
    end

endmodule

// ===== sv/rational_arith_reduce.sv =====
// Top level: fraction add, subtract, multiply or divide with reduction to lowest terms.
//
//   channel   signals                                          direction
//   request   req_valid, req_ready, action, left_*, right_*    into block
//   result    res_valid, res_ready, result_*, zero_denominator out of block
//
// A request passes the multiply and combine states, then the gcd loop and 2*RW division steps
// unless a term is zero, with RW = min(2*OPERAND_WIDTH+1, 64), and ends in the finish state.
// One multiplier serves the three cross products, and one subtractor serves the binary gcd
// and both restoring divisions, one step per cycle.
// req_ready is high only while the sequencer is idle; a finished result waits in the output
// register while a further request is accepted, and a full output register holds the sequencer.
// Reset clears the sequencer and the result valid flag.
`timescale 1ns / 1ps
module rational_arith_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic [1:0]                            action,
    input  logic signed [OPERAND_WIDTH-1:0]       left_numerator,
    input  logic signed [OPERAND_WIDTH-1:0]       left_denominator,
    input  logic signed [OPERAND_WIDTH-1:0]       right_numerator,
    input  logic signed [OPERAND_WIDTH-1:0]       right_denominator,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic signed [rar_pkg::NUM_WIDTH-1:0]  result_numerator,
    output logic signed [rar_pkg::DEN_WIDTH-1:0]  result_denominator,
    output logic                                  zero_denominator
);
    import rar_pkg::*;

    localparam int PW   = 2 * OPERAND_WIDTH;
    localparam int RW   = (2 * OPERAND_WIDTH + 1 > WIDE) ? WIDE : 2 * OPERAND_WIDTH + 1;
    localparam int SUBW = RW + 2;
    localparam int CW   = $clog2(RW);

    state_t state_reg, state_next;

    // Captured request.
    action_t                         act_reg, act_next;
    logic signed [OPERAND_WIDTH-1:0] ln_reg, ln_next;
    logic signed [OPERAND_WIDTH-1:0] ld_reg, ld_next;
    logic signed [OPERAND_WIDTH-1:0] rn_reg, rn_next;
    logic signed [OPERAND_WIDTH-1:0] rd_reg, rd_next;

    // Products and working values.
    logic signed [PW-1:0] p0_reg, p0_next;
    logic signed [PW-1:0] p1_reg, p1_next;
    logic                 sign_n_reg, sign_n_next;
    logic                 sign_d_reg, sign_d_next;
    logic                 dzero_reg, dzero_next;
    logic [RW-1:0]        x_reg, x_next;
    logic [RW-1:0]        y_reg, y_next;
    logic [RW-1:0]        na_reg, na_next;
    logic [RW-1:0]        da_reg, da_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    // Result register.
    logic                        res_valid_reg, res_valid_next;
    logic signed [NUM_WIDTH-1:0] rnum_reg, rnum_next;
    logic signed [DEN_WIDTH-1:0] rden_reg, rden_next;
    logic                        rzero_reg, rzero_next;

    // Shared units.
    logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
    logic signed [PW-1:0]            prod;
    logic [SUBW-1:0]                 sub_a, sub_b, sub_diff;
    sub_flags_t                      sub_flags;

    // Combined raw fraction and helpers.
    logic signed [RW-1:0]   num_raw, den_raw;
    logic [RW-1:0]          mag_n, mag_d;
    logic                   special;
    logic                   load_out;
    logic                   div_last;
    logic [RW:0]            trial;
    logic [RW-1:0]          num_s, den_s;
    logic signed [WIDE-1:0] num_wide, den_wide;

    rar_mul #(.WIDTH(OPERAND_WIDTH)) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    rar_sub #(.WIDTH(SUBW)) u_sub (
        .a     (sub_a),
        .b     (sub_b),
        .diff  (sub_diff),
        .flags (sub_flags)
    );

    // Raw numerator and denominator from the products; the last product is the denominator.
    always_comb
    begin
        case (act_reg)
            ACT_ADD: num_raw = RW'(p0_reg) + RW'(p1_reg);
            ACT_SUB: num_raw = RW'(p0_reg) - RW'(p1_reg);
            default: num_raw = RW'(p0_reg);
        endcase
        den_raw  = RW'(prod);
        mag_n    = num_raw[RW-1] ? RW'(-num_raw) : RW'(num_raw);
        mag_d    = den_raw[RW-1] ? RW'(-den_raw) : RW'(den_raw);
        special  = (mag_n == '0) || (mag_d == '0);
        div_last = (cnt_reg == CW'(RW - 1));
        load_out = (state_reg == S_FINISH) && (!res_valid_reg || res_ready);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0: state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_COMB;
            S_COMB: state_next = special ? S_FINISH : S_TWOS;
            S_TWOS:
            begin
                if (x_reg[0] || y_reg[0])
                begin
                    state_next = S_ODD;
                end
            end
            S_ODD:
            begin
                if (x_reg[0] && y_reg[0] && sub_flags.zero)
                begin
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (div_last)
                begin
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Unit operand selection and handshake outputs.
    always_comb
    begin
        req_ready = (state_reg == S_IDLE);
        mul_a     = ln_reg;
        mul_b     = rd_reg;
        sub_a     = SUBW'(x_reg);
        sub_b     = SUBW'(y_reg);
        trial     = {rem_reg, na_reg[RW-1]};
        case (state_reg)
            S_MUL0:
            begin
                mul_a = ln_reg;
                mul_b = (act_reg == ACT_MUL) ? rn_reg : rd_reg;
            end
            S_MUL1:
            begin
                mul_a = ld_reg;
                mul_b = rn_reg;
            end
            S_MUL2:
            begin
                mul_a = ld_reg;
                mul_b = (act_reg == ACT_DIV) ? rn_reg : rd_reg;
            end
            S_DIVN:
            begin
                trial = {rem_reg, na_reg[RW-1]};
                sub_a = SUBW'(trial);
            end
            S_DIVD:
            begin
                trial = {rem_reg, da_reg[RW-1]};
                sub_a = SUBW'(trial);
            end
            default:
            begin
                sub_a = SUBW'(x_reg);
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        act_next    = act_reg;
        ln_next     = ln_reg;
        ld_next     = ld_reg;
        rn_next     = rn_reg;
        rd_next     = rd_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        sign_n_next = sign_n_reg;
        sign_d_next = sign_d_reg;
        dzero_next  = dzero_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        na_next     = na_reg;
        da_next     = da_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next = action_t'(action);
                    ln_next  = left_numerator;
                    ld_next  = left_denominator;
                    rn_next  = right_numerator;
                    rd_next  = right_denominator;
                end
            end
            S_MUL1: p0_next = prod;
            S_MUL2: p1_next = prod;
            S_COMB:
            begin
                sign_n_next = num_raw[RW-1];
                sign_d_next = den_raw[RW-1];
                dzero_next  = (mag_d == '0);
                x_next      = mag_n;
                y_next      = mag_d;
                // A zero on either side leaves a unit magnitude on the other side.
                na_next     = RW'(mag_n != '0);
                da_next     = RW'(mag_d != '0);
            end
            S_TWOS:
            begin
                // Common factors of two come out of the dividends as well.
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                end
                else
                begin
                    na_next = x_reg;
                    da_next = y_reg;
                end
            end
            S_ODD:
            begin
                rem_next = '0;
                cnt_next = '0;
                if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (sub_flags.neg)
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else if (!sub_flags.zero)
                begin
                    x_next = sub_diff[RW-1:0];
                end
            end
            S_DIVN:
            begin
                rem_next = sub_flags.neg ? trial[RW-1:0] : sub_diff[RW-1:0];
                na_next  = {na_reg[RW-2:0], !sub_flags.neg};
                cnt_next = div_last ? '0 : cnt_reg + 1'b1;
                if (div_last)
                begin
                    rem_next = '0;
                end
            end
            S_DIVD:
            begin
                rem_next = sub_flags.neg ? trial[RW-1:0] : sub_diff[RW-1:0];
                da_next  = {da_reg[RW-2:0], !sub_flags.neg};
                cnt_next = div_last ? '0 : cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Result register: signs restored, then cut to the field widths.
    always_comb
    begin
        num_s          = sign_n_reg ? RW'(-na_reg) : na_reg;
        den_s          = sign_d_reg ? RW'(-da_reg) : da_reg;
        num_wide       = WIDE'($signed(num_s));
        den_wide       = WIDE'($signed(den_s));
        rnum_next      = rnum_reg;
        rden_next      = rden_reg;
        rzero_next     = rzero_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (load_out)
        begin
            rnum_next      = num_wide[NUM_WIDTH-1:0];
            rden_next      = den_wide[DEN_WIDTH-1:0];
            rzero_next     = dzero_reg;
            res_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        ln_reg     <= ln_next;
        ld_reg     <= ld_next;
        rn_reg     <= rn_next;
        rd_reg     <= rd_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        sign_n_reg <= sign_n_next;
        sign_d_reg <= sign_d_next;
        dzero_reg  <= dzero_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        na_reg     <= na_next;
        da_reg     <= da_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        rnum_reg   <= rnum_next;
        rden_reg   <= rden_next;
        rzero_reg  <= rzero_next;
    end

    assign res_valid          = res_valid_reg;
    assign result_numerator   = rnum_reg;
    assign result_denominator = rden_reg;
    assign zero_denominator   = rzero_reg;

    // Checks on the sequencer and datapath.
    `include "rational_arith_reduce_assert.svh"

    `RAR_ASSERT_NEXT(a_accept_starts, clk, rst_n, req_valid && req_ready, state_reg == S_MUL0 && !req_ready, "accepted request did not start the multiply sequence")
    `RAR_ASSERT_IMPLY(a_gcd_nonzero, clk, rst_n, state_reg == S_ODD, x_reg != '0 && y_reg != '0, "gcd loop reached a zero operand")
    `RAR_ASSERT_IMPLY(a_divisor_odd, clk, rst_n, state_reg == S_DIVN || state_reg == S_DIVD, y_reg[0], "divisor is not the odd gcd")
    `RAR_ASSERT_IMPLY(a_zero_flag, clk, rst_n, res_valid && zero_denominator, result_denominator == '0, "zero flag set with a nonzero denominator")

endmodule
